// ===== design/ffva_pkg.sv =====
// shared constants, codes and structs of the first-fit allocator
// used by the walker and the top level; no dependencies
package ffva_pkg;

	localparam int ARENA_WORDS  = 1024;
	localparam int WORD_BYTES   = 8;
	localparam int HEADER_WORDS = 1;
	localparam int WORD_SHIFT   = $clog2(WORD_BYTES);
	localparam int AW           = $clog2(ARENA_WORDS);
	localparam int HW           = AW + 2;

	typedef enum logic [1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [HW-1:0] wdata;
		logic [AW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic [12:0] grant_address;
		logic        ok;
		logic [13:0] largest_bytes;
	} result_t;

endpackage

// ===== design/first_fit_variable_size_allocator.sv =====
// top level of the first-fit allocator: header ram, walker, output register
// depends on ffva_pkg, ffva_ram and ffva_walker
//
// Input channel (in_valid/in_stall) carries kind, size_bytes and address.
// kind 0 allocates, 1 frees, 2 reports the largest free payload.
// Unless cfg_we restarts init, each transfer gives one result on the output
// channel (out_valid/out_stall): grant_address, ok and largest_bytes.
// One item is in work at a time; in_stall is high from the transfer until
// the result is handed to the output register.
// An item reads each block header that it visits in the chain; a free
// block takes one more read to find its end, and one more per free block
// merged into it: every step is one read of the header ram, whose data
// returns in the next cycle. A free stops at its target block.
// Reset, and every write of cfg_wdata through cfg_we, sets up one free
// block over the arena and an end marker during init, with in_stall
// high meanwhile. While out_stall holds a result, the next item is still
// taken and walked; it waits at its end until the output register frees.
module first_fit_variable_size_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [13:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [13:0] size_bytes,
	input  logic [12:0] address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [12:0] grant_address,
	output logic        ok,
	output logic [13:0] largest_bytes
);
	import ffva_pkg::*;

	mem_req_t       mem;
	logic [HW-1:0]  rdata;
	logic           busy, res_valid, res_take, in_xfer;
	result_t        res, out_q;
	logic           out_valid_q;

	assign in_stall = busy;
	assign in_xfer  = in_valid && !busy;
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	ffva_ram #(
		.DEPTH(ARENA_WORDS),
		.WIDTH(HW)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

	ffva_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_xfer    (in_xfer),
		.kind       (kind),
		.size_bytes (size_bytes),
		.address    (address),
		.busy       (busy),
		.mem        (mem),
		.rdata      (rdata),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (res_take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign grant_address = out_q.grant_address;
	assign ok            = out_q.ok;
	assign largest_bytes = out_q.largest_bytes;
endmodule

// ===== design/ffva_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module ffva_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/ffva_walker.sv =====
// chain walker: sequencer that reads, merges and rewrites block headers
// depends on ffva_pkg; drives the header ram through a mem_req_t
module ffva_walker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [13:0]              cfg_wdata,
	input  logic                     in_xfer,
	input  logic [1:0]               kind,
	input  logic [13:0]              size_bytes,
	input  logic [12:0]              address,
	output logic                     busy,
	output ffva_pkg::mem_req_t       mem,
	input  logic [ffva_pkg::HW-1:0]  rdata,
	output logic                     res_valid,
	output ffva_pkg::result_t        res,
	input  logic                     res_take
);
	import ffva_pkg::*;

	typedef enum logic [6:0] {
		ST_INIT0 = 7'b0000001,
		ST_INIT1 = 7'b0000010,
		ST_IDLE  = 7'b0000100,
		ST_RD    = 7'b0001000,
		ST_MRG   = 7'b0010000,
		ST_SPLIT = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t         state_q, state_d;
	kind_t          kind_q, kind_d;
	logic [13:0]    arena_q;
	logic [11:0]    need_q, need_d;
	logic [AW-1:0]  target_q, target_d;
	logic [AW-1:0]  p_q, p_d;
	logic [AW:0]    len_q, len_d;
	logic [AW:0]    best_q, best_d;
	result_t        res_q, res_d;

	logic [11:0]    words_raw, words;
	logic [11:0]    need_in;
	logic [AW-1:0]  end_idx;
	logic           h_zero, h_neg;
	logic [AW:0]    h_abs, step;
	logic [AW:0]    nx_abs;
	logic           run_go, run_stop;
	logic [AW:0]    run_len, run_q;
	logic [12:0]    goal, rest;
	logic [AW:0]    grant_word;

	// arena word count, saturated to the legal range
	assign words_raw = 12'((15'(arena_q) + 15'(WORD_BYTES - 1)) >> WORD_SHIFT);
	always_comb begin
		if (words_raw < 12'(2 * HEADER_WORDS)) begin
			words = 12'(2 * HEADER_WORDS);
		end else if (words_raw > 12'(ARENA_WORDS)) begin
			words = 12'(ARENA_WORDS);
		end else begin
			words = words_raw;
		end
	end
	assign end_idx = AW'(words - 12'(HEADER_WORDS));
	assign need_in = 12'((15'(size_bytes) + 15'(WORD_BYTES - 1)) >> WORD_SHIFT);

	assign h_zero = (rdata == '0);
	assign h_neg  = rdata[HW-1];
	assign h_abs  = h_neg ? (AW+1)'(-rdata) : (AW+1)'(rdata);
	assign nx_abs = (AW+1)'(rdata);
	assign step   = {1'b0, p_q} + h_abs;
	assign goal   = 13'(need_q) + 13'(HEADER_WORDS);

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		need_d   = need_q;
		target_d = target_q;
		p_d      = p_q;
		len_d    = len_q;
		best_d   = best_q;
		res_d    = res_q;
		mem      = '0;
		run_go   = 1'b0;
		run_stop = 1'b0;
		run_len  = '0;
		run_q    = '0;
		rest     = '0;
		grant_word = '0;
		case (state_q)
			ST_INIT0: begin
				mem.we    = 1'b1;
				mem.waddr = '0;
				mem.wdata = HW'(words - 12'(HEADER_WORDS));
				state_d   = ST_INIT1;
			end
			ST_INIT1: begin
				// end marker
				mem.we    = 1'b1;
				mem.waddr = end_idx;
				mem.wdata = '0;
				state_d   = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_xfer) begin
					kind_d   = kind_t'(kind);
					need_d   = need_in;
					target_d = AW'((address >> WORD_SHIFT) - 13'(HEADER_WORDS));
					p_d      = '0;
					best_d   = '0;
					res_d    = '0;
					mem.raddr = '0;
					case (kind_t'(kind))
						KIND_ALLOC: state_d = (need_in == '0) ? ST_DONE : ST_RD;
						KIND_FREE: begin
							if (address == '0 || address[WORD_SHIFT-1:0] != '0) begin
								state_d = ST_DONE;
							end else begin
								state_d = ST_RD;
							end
						end
						KIND_QUERY: state_d = ST_RD;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_RD: begin
				if (h_zero) begin
					if (kind_q == KIND_QUERY) begin
						res_d.ok            = 1'b1;
						res_d.largest_bytes = 14'({best_q, {WORD_SHIFT{1'b0}}});
					end
					state_d = ST_DONE;
				end else if (kind_q == KIND_FREE) begin
					if (p_q == target_q) begin
						if (h_neg) begin
							mem.we    = 1'b1;
							mem.waddr = p_q;
							mem.wdata = HW'(-rdata);
							res_d.ok  = 1'b1;
						end
						state_d = ST_DONE;
					end else if (step > {1'b0, target_q}) begin
						state_d = ST_DONE;
					end else begin
						p_d       = step[AW-1:0];
						mem.raddr = step[AW-1:0];
					end
				end else if (h_neg) begin
					if (step[AW]) begin
						if (kind_q == KIND_QUERY) begin
							res_d.ok            = 1'b1;
							res_d.largest_bytes = 14'({best_q, {WORD_SHIFT{1'b0}}});
						end
						state_d = ST_DONE;
					end else begin
						p_d       = step[AW-1:0];
						mem.raddr = step[AW-1:0];
					end
				end else begin
					run_go  = 1'b1;
					run_len = h_abs;
				end
			end
			ST_MRG: begin
				run_go = 1'b1;
				if (h_zero || h_neg) begin
					run_stop = 1'b1;
					run_len  = len_q;
				end else begin
					run_len = len_q + nx_abs;
				end
			end
			ST_SPLIT: begin
				mem.we    = 1'b1;
				mem.waddr = AW'(13'(p_q) + goal);
				mem.wdata = HW'(len_q);
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		// a free block run: fit check, keep merging, or write it back and move on
		if (run_go) begin
			run_q = {1'b0, p_q} + run_len;
			if (kind_q == KIND_ALLOC && 13'(run_len) >= goal) begin
				rest       = 13'(run_len) - goal;
				grant_word = {1'b0, p_q} + (AW+1)'(HEADER_WORDS);
				res_d.ok            = 1'b1;
				res_d.grant_address = 13'({grant_word, {WORD_SHIFT{1'b0}}});
				mem.we    = 1'b1;
				mem.waddr = p_q;
				if (rest >= 13'(HEADER_WORDS + 1)) begin
					mem.wdata = HW'(-goal);
					len_d     = (AW+1)'(rest);
					state_d   = ST_SPLIT;
				end else begin
					mem.wdata = -HW'(run_len);
					state_d   = ST_DONE;
				end
			end else if (!run_stop && !run_q[AW]) begin
				len_d     = run_len;
				mem.raddr = run_q[AW-1:0];
				state_d   = ST_MRG;
			end else begin
				mem.we    = 1'b1;
				mem.waddr = p_q;
				mem.wdata = HW'(run_len);
				if (kind_q == KIND_QUERY &&
				    run_len - (AW+1)'(HEADER_WORDS) > best_d) begin
					best_d = run_len - (AW+1)'(HEADER_WORDS);
				end
				if (run_q[AW]) begin
					if (kind_q == KIND_QUERY) begin
						res_d.ok            = 1'b1;
						res_d.largest_bytes = 14'({best_d, {WORD_SHIFT{1'b0}}});
					end
					state_d = ST_DONE;
				end else begin
					p_d       = run_q[AW-1:0];
					mem.raddr = run_q[AW-1:0];
					state_d   = ST_RD;
				end
			end
		end

		// a register write reinitialises the arena
		if (cfg_we) begin
			state_d = ST_INIT0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT0;
			arena_q <= 14'd8192;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				arena_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		need_q   <= need_d;
		target_q <= target_d;
		p_q      <= p_d;
		len_q    <= len_d;
		best_q   <= best_d;
		res_q    <= res_d;
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;
endmodule

// ===== design/ffva_checker.sv =====
// port-level checks of the first-fit allocator, bound to the top level
// depends on first_fit_variable_size_allocator
module ffva_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [12:0] grant_address,
	input logic        ok,
	input logic [13:0] largest_bytes
);
	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one item at a time: a transfer closes the input side
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while walking");

	// a grant is word aligned and only reported with ok
	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && grant_address != 13'd0 |-> ok && grant_address[2:0] == 3'd0)
		else $error("bad grant address");

	// a largest-free report only comes with ok and no grant
	a_query: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && largest_bytes != 14'd0 |-> ok && grant_address == 13'd0)
		else $error("bad query result");
endmodule

bind first_fit_variable_size_allocator ffva_checker u_ffva_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.grant_address (grant_address),
	.ok            (ok),
	.largest_bytes (largest_bytes)
);
